// ===== hw/rtl/vector2d_fixed_alu_macros.svh =====
// Assertion macros used by the vector ALU execution pipeline.
`ifndef VECTOR2D_FIXED_ALU_MACROS_SVH
`define VECTOR2D_FIXED_ALU_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define V2F_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define V2F_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/v2f_pkg.sv =====
// Types and constants of the two-dimensional fixed-point vector ALU.
package v2f_pkg;

	localparam int FRAC_BITS = 16;
	localparam int WORD_BITS = 32;

	localparam logic [2:0] FUNC_ADD   = 3'd0;
	localparam logic [2:0] FUNC_SUB   = 3'd1;
	localparam logic [2:0] FUNC_SCALE = 3'd2;
	localparam logic [2:0] FUNC_LEN   = 3'd3;
	localparam logic [2:0] FUNC_NORM  = 3'd4;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	localparam int SQ_STEPS  = WORD_BITS;
	localparam int DIV_STEPS = FRAC_BITS + 1;

	typedef enum logic [2:0] {
		CLS_ADD,
		CLS_SUB,
		CLS_SCALE,
		CLS_LEN,
		CLS_NORM,
		CLS_NONE
	} cls_t;

	typedef struct packed {
		logic [2:0]                  func;
		logic signed [WORD_BITS-1:0] first_x;
		logic signed [WORD_BITS-1:0] first_y;
		logic signed [WORD_BITS-1:0] second_x;
		logic signed [WORD_BITS-1:0] second_y;
		logic signed [WORD_BITS-1:0] factor;
	} cmd_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] result_x;
		logic signed [WORD_BITS-1:0] result_y;
		logic [WORD_BITS-1:0]        result_length;
		logic                        overflow;
		logic                        zero_vector;
	} res_t;

	typedef struct packed {
		cls_t                        cls;
		logic signed [WORD_BITS-1:0] ax;
		logic signed [WORD_BITS-1:0] ay;
		logic signed [WORD_BITS-1:0] bx;
		logic signed [WORD_BITS-1:0] by;
		logic signed [WORD_BITS-1:0] f;
	} entry_t;

endpackage

// ===== hw/rtl/vector2d_fixed_alu.sv =====
// Top level of the two-dimensional Q16.16 vector ALU.
// A command is taken on a clock edge with start high and busy low, one per
// cycle; every command gives exactly one result, shown on res for the single
// cycle in which done is high, in command order. Each result passes through
// the queue, a multiply stage and a sum stage, 32 square-root stages, 17
// division stages and one output register; add, subtract, scale and length
// ride the same pipeline so that order holds. The receiver cannot hold
// results off, so the pipeline never stalls and busy stays low in practice.
module vector2d_fixed_alu import v2f_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output res_t res
);

	logic   push;
	entry_t wr_entry;
	logic   q_full;
	logic   q_vld;
	entry_t rd_entry;

	assign busy = q_full;

	v2f_front u_front (
		.start (start),
		.busy  (q_full),
		.cmd   (cmd),
		.push  (push),
		.entry (wr_entry)
	);

	v2f_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.full     (q_full),
		.vld      (q_vld),
		.rd_entry (rd_entry)
	);

	v2f_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (q_vld),
		.entry  (rd_entry),
		.done   (done),
		.res    (res)
	);

endmodule

// ===== hw/rtl/v2f_front.sv =====
// Front end: takes commands and classifies the operation.
module v2f_front import v2f_pkg::*; (
	input  logic   start,
	input  logic   busy,
	input  cmd_t   cmd,
	output logic   push,
	output entry_t entry
);

	cls_t cls;

	always_comb begin
		case (cmd.func)
			FUNC_ADD:   cls = CLS_ADD;
			FUNC_SUB:   cls = CLS_SUB;
			FUNC_SCALE: cls = CLS_SCALE;
			FUNC_LEN:   cls = CLS_LEN;
			FUNC_NORM:  cls = CLS_NORM;
			default:    cls = CLS_NONE;
		endcase
	end

	assign push     = start & ~busy;
	assign entry.cls = cls;
	assign entry.ax  = cmd.first_x;
	assign entry.ay  = cmd.first_y;
	assign entry.bx  = cmd.second_x;
	assign entry.by  = cmd.second_y;
	assign entry.f   = cmd.factor;

endmodule

// ===== hw/rtl/v2f_queue.sv =====
// Short queue between the front end and the execution pipeline.
module v2f_queue import v2f_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wr_entry,
	output logic   full,
	output logic   vld,
	output entry_t rd_entry
);

	entry_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_q;
	logic [Q_PTR_W-1:0]   rd_q;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic                 pop;

	// The back end never stalls, so whatever is queued leaves next cycle.
	assign vld      = (cnt_q != '0);
	assign pop      = vld;
	assign full     = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign rd_entry = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/v2f_back.sv =====
// Execution pipeline: add, subtract, scale, square root and normalize.
`include "vector2d_fixed_alu_macros.svh"
module v2f_back import v2f_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   vld,
	input  entry_t entry,
	output logic   done,
	output res_t   res
);

	localparam int W  = WORD_BITS;
	localparam int RW = W + 2;

	typedef struct packed {
		cls_t           cls;
		logic [W-1:0]   vx;
		logic [W-1:0]   vy;
		logic           ov;
		logic [W-1:0]   max;
		logic [W-1:0]   may;
		logic           sgnx;
		logic           sgny;
	} pl_t;

	function automatic logic [W-1:0] mag_of(input logic [W-1:0] a);
		mag_of = a[W-1] ? (~a + 1'b1) : a;
	endfunction

	// Saturate a sign-extended sum or difference to a word; bit W is the overflow flag.
	function automatic logic [W:0] sat_sum(input logic [W:0] s);
		logic [W-1:0] v;
		logic         o;
		o = (s[W] != s[W-1]);
		if (!o) begin
			v = s[W-1:0];
		end else if (s[W]) begin
			v = {1'b1, {(W-1){1'b0}}};
		end else begin
			v = {1'b0, {(W-1){1'b1}}};
		end
		sat_sum = {o, v};
	endfunction

	// Round the magnitude product, drop the fraction and saturate.
	function automatic logic [W:0] scale_fin(input logic [2*W-1:0] p, input logic neg);
		logic [2*W:0]         rnd;
		logic [2*W-FRAC_BITS:0] m;
		logic [2*W-FRAC_BITS:0] lim;
		logic                 o;
		logic [W-1:0]         mm;
		rnd = {1'b0, p} + ((2*W+1)'(1) << (FRAC_BITS - 1));
		m   = rnd[2*W:FRAC_BITS];
		lim = (2*W-FRAC_BITS+1)'({1'b0, {(W-1){1'b1}}}) + (2*W-FRAC_BITS+1)'(neg);
		o   = (m > lim);
		mm  = o ? lim[W-1:0] : m[W-1:0];
		scale_fin = {o, neg ? (~mm + 1'b1) : mm};
	endfunction

	// Stage 1: magnitudes, products and the add or subtract.
	logic           vld_s1;
	cls_t           cls_s1;
	logic [W-1:0]   max_s1, may_s1;
	logic           sgnx_s1, sgny_s1, negx_s1, negy_s1;
	logic [2*W-1:0] sqx_s1, sqy_s1, pfx_s1, pfy_s1;
	logic [W-1:0]   ax_s1, ay_s1;
	logic           aov_s1;

	logic [W-1:0] max_c, may_c, mf_c;
	logic [W:0]   sx_c, sy_c, rx_c, ry_c;

	always_comb begin
		max_c = mag_of(entry.ax);
		may_c = mag_of(entry.ay);
		mf_c  = mag_of(entry.f);
		if (entry.cls == CLS_SUB) begin
			sx_c = {entry.ax[W-1], entry.ax} - {entry.bx[W-1], entry.bx};
			sy_c = {entry.ay[W-1], entry.ay} - {entry.by[W-1], entry.by};
		end else begin
			sx_c = {entry.ax[W-1], entry.ax} + {entry.bx[W-1], entry.bx};
			sy_c = {entry.ay[W-1], entry.ay} + {entry.by[W-1], entry.by};
		end
		rx_c = sat_sum(sx_c);
		ry_c = sat_sum(sy_c);
	end

	always_ff @(posedge clk) begin
		cls_s1  <= entry.cls;
		max_s1  <= max_c;
		may_s1  <= may_c;
		sgnx_s1 <= entry.ax[W-1];
		sgny_s1 <= entry.ay[W-1];
		negx_s1 <= entry.ax[W-1] ^ entry.f[W-1];
		negy_s1 <= entry.ay[W-1] ^ entry.f[W-1];
		sqx_s1  <= {{W{1'b0}}, max_c} * {{W{1'b0}}, max_c};
		sqy_s1  <= {{W{1'b0}}, may_c} * {{W{1'b0}}, may_c};
		pfx_s1  <= {{W{1'b0}}, max_c} * {{W{1'b0}}, mf_c};
		pfy_s1  <= {{W{1'b0}}, may_c} * {{W{1'b0}}, mf_c};
		ax_s1   <= rx_c[W-1:0];
		ay_s1   <= ry_c[W-1:0];
		aov_s1  <= rx_c[W] | ry_c[W];
	end

	// Stage 2: sum of squares and the scale result.
	logic           vld_s2;
	pl_t            pl_s2;
	logic [2*W-1:0] rad_s2;
	logic [W:0]     scx_c, scy_c;

	always_comb begin
		scx_c = scale_fin(pfx_s1, negx_s1);
		scy_c = scale_fin(pfy_s1, negy_s1);
	end

	always_ff @(posedge clk) begin
		pl_s2.cls  <= cls_s1;
		pl_s2.max  <= max_s1;
		pl_s2.may  <= may_s1;
		pl_s2.sgnx <= sgnx_s1;
		pl_s2.sgny <= sgny_s1;
		rad_s2     <= sqx_s1 + sqy_s1;
		if (cls_s1 == CLS_SCALE) begin
			pl_s2.vx <= scx_c[W-1:0];
			pl_s2.vy <= scy_c[W-1:0];
			pl_s2.ov <= scx_c[W] | scy_c[W];
		end else begin
			pl_s2.vx <= ax_s1;
			pl_s2.vy <= ay_s1;
			pl_s2.ov <= aov_s1;
		end
	end

	// Square root, one result bit per stage.
	logic           vld_sq  [SQ_STEPS+1];
	pl_t            pl_sq   [SQ_STEPS+1];
	logic [RW-1:0]  rem_sq  [SQ_STEPS+1];
	logic [W-1:0]   root_sq [SQ_STEPS+1];
	logic [2*W-1:0] rad_sq  [SQ_STEPS+1];

	assign vld_sq[0]  = vld_s2;
	assign pl_sq[0]   = pl_s2;
	assign rem_sq[0]  = '0;
	assign root_sq[0] = '0;
	assign rad_sq[0]  = rad_s2;

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		logic [RW+1:0] cur;
		logic [RW+1:0] trial;
		logic          ge;
		always_comb begin
			cur   = {rem_sq[k], rad_sq[k][2*W-1:2*W-2]};
			trial = {2'b00, root_sq[k], 2'b01};
			ge    = (cur >= trial);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sq[k+1] <= 1'b0;
			end else begin
				vld_sq[k+1] <= vld_sq[k];
			end
		end
		always_ff @(posedge clk) begin
			pl_sq[k+1]   <= pl_sq[k];
			rem_sq[k+1]  <= ge ? RW'(cur - trial) : cur[RW-1:0];
			root_sq[k+1] <= {root_sq[k][W-2:0], ge};
			rad_sq[k+1]  <= {rad_sq[k][2*W-3:0], 2'b00};
		end
	end

	// Normalize division, one quotient bit per stage, both components at once.
	logic               vld_dv  [DIV_STEPS+1];
	pl_t                pl_dv   [DIV_STEPS+1];
	logic [W-1:0]       len_dv  [DIV_STEPS+1];
	logic [W-1:0]       remx_dv [DIV_STEPS+1];
	logic [W-1:0]       remy_dv [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] qx_dv [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] qy_dv [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] fx_dv [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] fy_dv [DIV_STEPS+1];

	// The dividend is the magnitude shifted up by the fraction width; since the
	// magnitude never exceeds the length, its top bits are already below it.
	assign vld_dv[0]  = vld_sq[SQ_STEPS];
	assign pl_dv[0]   = pl_sq[SQ_STEPS];
	assign len_dv[0]  = root_sq[SQ_STEPS];
	assign remx_dv[0] = {1'b0, pl_sq[SQ_STEPS].max[W-1:1]};
	assign remy_dv[0] = {1'b0, pl_sq[SQ_STEPS].may[W-1:1]};
	assign qx_dv[0]   = '0;
	assign qy_dv[0]   = '0;
	assign fx_dv[0]   = {pl_sq[SQ_STEPS].max[0], {(DIV_STEPS-1){1'b0}}};
	assign fy_dv[0]   = {pl_sq[SQ_STEPS].may[0], {(DIV_STEPS-1){1'b0}}};

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [W:0] curx, cury, dvs;
		logic       gex, gey;
		always_comb begin
			curx = {remx_dv[j], fx_dv[j][DIV_STEPS-1]};
			cury = {remy_dv[j], fy_dv[j][DIV_STEPS-1]};
			dvs  = {1'b0, len_dv[j]};
			gex  = (curx >= dvs);
			gey  = (cury >= dvs);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_dv[j+1] <= 1'b0;
			end else begin
				vld_dv[j+1] <= vld_dv[j];
			end
		end
		always_ff @(posedge clk) begin
			pl_dv[j+1]   <= pl_dv[j];
			len_dv[j+1]  <= len_dv[j];
			remx_dv[j+1] <= gex ? W'(curx - dvs) : curx[W-1:0];
			remy_dv[j+1] <= gey ? W'(cury - dvs) : cury[W-1:0];
			qx_dv[j+1]   <= {qx_dv[j][DIV_STEPS-2:0], gex};
			qy_dv[j+1]   <= {qy_dv[j][DIV_STEPS-2:0], gey};
			fx_dv[j+1]   <= {fx_dv[j][DIV_STEPS-2:0], 1'b0};
			fy_dv[j+1]   <= {fy_dv[j][DIV_STEPS-2:0], 1'b0};
		end
	end

	// Final rounding and result selection.
	pl_t              plf;
	logic [W-1:0]     lenf;
	logic [DIV_STEPS:0] nqx, nqy;
	logic [W-1:0]     nx, ny;
	res_t             res_c;
	logic             done_q;
	res_t             res_q;

	always_comb begin
		plf  = pl_dv[DIV_STEPS];
		lenf = len_dv[DIV_STEPS];
		nqx  = {1'b0, qx_dv[DIV_STEPS]} +
			(DIV_STEPS+1)'({remx_dv[DIV_STEPS], 1'b0} >= {1'b0, lenf});
		nqy  = {1'b0, qy_dv[DIV_STEPS]} +
			(DIV_STEPS+1)'({remy_dv[DIV_STEPS], 1'b0} >= {1'b0, lenf});
		nx   = plf.sgnx ? (~W'(nqx) + 1'b1) : W'(nqx);
		ny   = plf.sgny ? (~W'(nqy) + 1'b1) : W'(nqy);
		res_c = '0;
		case (plf.cls)
			CLS_ADD, CLS_SUB, CLS_SCALE: begin
				res_c.result_x = plf.vx;
				res_c.result_y = plf.vy;
				res_c.overflow = plf.ov;
			end
			CLS_LEN: begin
				res_c.result_length = lenf;
			end
			CLS_NORM: begin
				if (lenf == '0) begin
					res_c.zero_vector = 1'b1;
				end else begin
					res_c.result_x = nx;
					res_c.result_y = ny;
				end
			end
			default: begin
				res_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			done_q <= vld_dv[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_c;
	end

	assign done = done_q;
	assign res  = res_q;

	`V2F_NEXT(a_s1_to_s2, vld_s1, vld_s2, "stage 1 item lost before stage 2")
	`V2F_IMPLY(a_len_only, done && res.result_length != '0, res.result_x == '0 && res.result_y == '0 && !res.overflow, "length result carries vector data")
	`V2F_IMPLY(a_zero_vec, done && res.zero_vector, res.result_x == '0 && res.result_y == '0 && !res.overflow, "zero vector result not cleared")
	`V2F_IMPLY(a_ovf_vec, done && res.overflow, res.result_length == '0 && !res.zero_vector, "overflow flagged on a non-vector operation")

endmodule

// ===== tb/tb_vector2d_fixed_alu.sv =====
// Testbench for the Q16.16 two-dimensional vector ALU: directed and random commands.
`timescale 1ns / 1ps

module tb_vector2d_fixed_alu;
	import v2f_pkg::*;

	localparam logic [2:0] FUNC_LAST = 3'd7;
	localparam int DRAIN_CYCLES = 60;
	localparam int RANDOM_COUNT = 1830;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic done;
	res_t res;

	res_t expected_results[$];
	int   error_count = 0;
	bit   idle_enabled = 1'b1;

	vector2d_fixed_alu dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.res(res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3ms;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [31:0] saturate_word(longint v, inout bit ov);
		longint hi = 64'sd2147483647;
		longint lo = -64'sd2147483648;
		if (v > hi) begin
			ov = 1'b1;
			return hi[31:0];
		end
		if (v < lo) begin
			ov = 1'b1;
			return lo[31:0];
		end
		return v[31:0];
	endfunction

	function automatic logic [31:0] scale_part(longint a, longint f, inout bit ov);
		bit neg = (a < 0) != (f < 0);
		longint unsigned ma = (a < 0) ? -a : a;
		longint unsigned mf = (f < 0) ? -f : f;
		longint unsigned mag;
		longint unsigned limit;
		// Round half away from zero on the magnitude, then clamp.
		mag = (ma * mf + 64'd32768) >> FRAC_BITS;
		limit = 64'd2147483647 + (neg ? 64'd1 : 64'd0);
		if (mag > limit) begin
			ov = 1'b1;
			mag = limit;
		end
		return neg ? (-mag) : mag;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned s);
		longint unsigned r = 0;
		longint unsigned t;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= s)
				r = t;
		end
		return r;
	endfunction

	function automatic logic [31:0] unit_part(longint a, longint unsigned len);
		longint unsigned m = (a < 0) ? -a : a;
		longint unsigned n = m << FRAC_BITS;
		longint unsigned q = n / len;
		longint unsigned rem = n % len;
		if (rem >= len - rem)
			q++;
		return (a < 0) ? (-q) : q;
	endfunction

	function automatic res_t predict_result(cmd_t c);
		res_t r = '0;
		bit ov = 1'b0;
		longint ax = c.first_x;
		longint ay = c.first_y;
		longint bx = c.second_x;
		longint by = c.second_y;
		longint f = c.factor;
		longint unsigned mx = (ax < 0) ? -ax : ax;
		longint unsigned my = (ay < 0) ? -ay : ay;
		longint unsigned len;
		len = floor_sqrt(mx * mx + my * my);
		case (c.func)
			FUNC_ADD: begin
				r.result_x = saturate_word(ax + bx, ov);
				r.result_y = saturate_word(ay + by, ov);
			end
			FUNC_SUB: begin
				r.result_x = saturate_word(ax - bx, ov);
				r.result_y = saturate_word(ay - by, ov);
			end
			FUNC_SCALE: begin
				r.result_x = scale_part(ax, f, ov);
				r.result_y = scale_part(ay, f, ov);
			end
			FUNC_LEN: begin
				r.result_length = len[31:0];
			end
			FUNC_NORM: begin
				if (len == 0) begin
					r.zero_vector = 1'b1;
				end else begin
					r.result_x = unit_part(ax, len);
					r.result_y = unit_part(ay, len);
				end
			end
			default: begin
			end
		endcase
		r.overflow = ov;
		return r;
	endfunction

	// Every completed result is checked against the oldest pending prediction.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, res);
				error_count++;
			end else begin
				res_t e;
				e = expected_results.pop_front();
				if (res.result_x !== e.result_x) begin
					$display("%0t: result_x expected %h actual %h", $time,
						e.result_x, res.result_x);
					error_count++;
				end
				if (res.result_y !== e.result_y) begin
					$display("%0t: result_y expected %h actual %h", $time,
						e.result_y, res.result_y);
					error_count++;
				end
				if (res.result_length !== e.result_length) begin
					$display("%0t: result_length expected %h actual %h", $time,
						e.result_length, res.result_length);
					error_count++;
				end
				if (res.overflow !== e.overflow) begin
					$display("%0t: overflow expected %b actual %b", $time,
						e.overflow, res.overflow);
					error_count++;
				end
				if (res.zero_vector !== e.zero_vector) begin
					$display("%0t: zero_vector expected %b actual %b", $time,
						e.zero_vector, res.zero_vector);
					error_count++;
				end
			end
		end
	end

	// Holds start until the transfer happens, then, if idling is enabled, idles a random number of cycles.
	task automatic send_command(cmd_t c);
		int gap;
		@(negedge clk);
		start <= 1'b1;
		cmd <= c;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		expected_results.push_back(predict_result(c));
		gap = idle_enabled ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			cmd <= '0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	function automatic cmd_t make_cmd(logic [2:0] func, logic [31:0] ax, logic [31:0] ay,
			logic [31:0] bx, logic [31:0] by, logic [31:0] f);
		cmd_t c;
		c.func = func;
		c.first_x = ax;
		c.first_y = ay;
		c.second_x = bx;
		c.second_y = by;
		c.factor = f;
		return c;
	endfunction

	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
			3: return $urandom_range(0, 3) - 2;
			4: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_add_sub();
		send_command(make_cmd(FUNC_ADD, 32'h0001_8000, 32'hfffe_0000, 32'h0000_8000,
			32'h0003_0000, '0));
		send_command(make_cmd(FUNC_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001,
			32'hffff_ffff, '0));
		send_command(make_cmd(FUNC_ADD, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff, 32'h0, '0));
		send_command(make_cmd(FUNC_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001,
			32'hffff_ffff, '0));
		send_command(make_cmd(FUNC_SUB, 32'h0, 32'h0, 32'h8000_0000, 32'h7fff_ffff, '0));
	endtask

	task automatic test_scale();
		send_command(make_cmd(FUNC_SCALE, 32'h0002_0000, 32'hfffd_0000, '0, '0,
			32'h0000_8000));
		send_command(make_cmd(FUNC_SCALE, 32'h0000_0001, 32'hffff_ffff, '0, '0,
			32'h0000_8000));
		send_command(make_cmd(FUNC_SCALE, 32'h7fff_ffff, 32'h8000_0000, '0, '0,
			32'h7fff_ffff));
		send_command(make_cmd(FUNC_SCALE, 32'h8000_0000, 32'h4000_0000, '0, '0,
			32'hffff_0000));
		send_command(make_cmd(FUNC_SCALE, 32'h8000_0000, 32'h8000_0000, '0, '0,
			32'h8000_0000));
	endtask

	task automatic test_length();
		send_command(make_cmd(FUNC_LEN, 32'h0003_0000, 32'h0004_0000, 32'hffff_ffff,
			32'hffff_ffff, 32'hffff_ffff));
		send_command(make_cmd(FUNC_LEN, 32'h8000_0000, 32'h8000_0000, '0, '0, '0));
		send_command(make_cmd(FUNC_LEN, 32'h0, 32'h0, '0, '0, '0));
		send_command(make_cmd(FUNC_LEN, 32'h7fff_ffff, 32'h0000_0001, '0, '0, '0));
	endtask

	task automatic test_normalize();
		send_command(make_cmd(FUNC_NORM, 32'h0, 32'h0, 32'h1234_5678, '0, 32'h0001_0000));
		send_command(make_cmd(FUNC_NORM, 32'h0003_0000, 32'hfffc_0000, '0, '0, '0));
		send_command(make_cmd(FUNC_NORM, 32'h8000_0000, 32'h7fff_ffff, '0, '0, '0));
		send_command(make_cmd(FUNC_NORM, 32'h0000_0001, 32'h0, '0, '0, '0));
		send_command(make_cmd(FUNC_NORM, 32'hffff_ffff, 32'hffff_ffff, '0, '0, '0));
	endtask

	task automatic test_unknown_func();
		for (logic [3:0] fn = 4'(FUNC_NORM) + 4'd1; fn <= 4'(FUNC_LAST); fn++)
			send_command(make_cmd(fn[2:0], 32'h7fff_ffff, 32'h8000_0000, 32'h1,
				32'hffff_ffff, 32'h0001_0000));
	endtask

	task automatic test_random();
		cmd_t c;
		for (int i = 0; i < RANDOM_COUNT; i++) begin
			// Every 64 commands, pick at random whether the next run is back-to-back or idles.
			if (i % 64 == 0)
				idle_enabled = $urandom_range(0, 2) != 0;
			c = make_cmd($urandom_range(0, 9) == 0 ? 3'($urandom_range(0, 7))
				: 3'($urandom_range(FUNC_ADD, FUNC_NORM)),
				random_word(), random_word(), random_word(), random_word(), random_word());
			if ($urandom_range(0, 30) == 0) begin
				c.first_x = '0;
				c.first_y = '0;
			end
			send_command(c);
		end
		idle_enabled = 1'b1;
	endtask

	initial begin
		int wait_cycles;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_add_sub();
		test_scale();
		test_length();
		test_normalize();
		test_unknown_func();
		test_random();

		@(negedge clk);
		start <= 1'b0;
		cmd <= '0;
		wait_cycles = 0;
		while (expected_results.size() != 0 && wait_cycles < 1000) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (expected_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_results.size());
			error_count++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
